// ===== src/tdp_pkg.sv =====
// ----------------------------------------------------------------------------
// tdp_pkg
// Shared constants, result codes and controller/datapath signal groups for
// the two-dimensional parity checker.
// ----------------------------------------------------------------------------
package tdp_pkg;

	localparam int MAX_SIZE_DEF = 64;
	localparam int SIZE_W       = 7;
	localparam int VERDICT_W    = 2;
	localparam int INDEX_W      = 7;

	localparam logic [SIZE_W-1:0]    SIZE_RESET      = 7'd1;

	localparam logic [VERDICT_W-1:0] VERDICT_OK      = 2'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_SINGLE  = 2'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_CORRUPT = 2'd2;

	localparam logic [1:0] COUNT_NONE = 2'd0;
	localparam logic [1:0] COUNT_ONE  = 2'd1;
	localparam logic [1:0] COUNT_SAT  = 2'd2;

	typedef struct packed {
		logic accum;
		logic scan;
		logic load;
		logic clear;
	} tdp_cmd_t;

	typedef struct packed {
		logic matrix_end;
		logic scan_last;
	} tdp_stat_t;

endpackage

// ===== src/tdp_bit_if.sv =====
// ----------------------------------------------------------------------------
// tdp_bit_if
// Input stream channel: one matrix bit per transfer.
// ----------------------------------------------------------------------------
interface tdp_bit_if;
	logic valid;
	logic ready;
	logic data_bit;

	modport source (output valid, output data_bit, input ready);
	modport sink   (input valid, input data_bit, output ready);
endinterface

// ===== src/tdp_result_if.sv =====
// ----------------------------------------------------------------------------
// tdp_result_if
// Result channel: one verdict with the located row and column per transfer.
// ----------------------------------------------------------------------------
interface tdp_result_if
	import tdp_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [VERDICT_W-1:0] verdict;
	logic [INDEX_W-1:0]   error_row;
	logic [INDEX_W-1:0]   error_column;

	modport source (output valid, output verdict, output error_row, output error_column,
		input ready);
	modport sink   (input valid, input verdict, input error_row, input error_column,
		output ready);
endinterface

// ===== src/tdp_cfg_if.sv =====
// ----------------------------------------------------------------------------
// tdp_cfg_if
// Configuration write channel for the matrix size register.
// ----------------------------------------------------------------------------
interface tdp_cfg_if
	import tdp_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [SIZE_W-1:0] matrix_size;

	modport source (output valid, output matrix_size, input ready);
	modport sink   (input valid, input matrix_size, output ready);
endinterface

// ===== src/tdp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdp_ctrl
// Controller: accepts bits while running, steps the column scan after the
// final bit, and owns the result valid flag.
// ----------------------------------------------------------------------------
module tdp_ctrl
	import tdp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  tdp_stat_t stat,
	output tdp_cmd_t  cmd
);

	localparam logic ST_RUN  = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = (state_q == ST_RUN);
	assign in_ready  = (state_q == ST_RUN) && !cfg_valid;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		if (cfg_valid && cfg_ready) begin
			cmd.clear = 1'b1;
		end else begin
			case (state_q)
				ST_RUN: begin
					cmd.accum = in_valid;
				end
				ST_SCAN: begin
					cmd.scan = !stat.scan_last || out_free;
					cmd.load = stat.scan_last && out_free;
				end
				default: begin
					cmd = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else if (cmd.clear || cmd.load) begin
			state_q <= ST_RUN;
		end else if (cmd.accum && stat.matrix_end) begin
			state_q <= ST_SCAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (state_q == ST_SCAN) && out_free)
		else $error("result loaded outside scan or over a pending result");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> out_valid_q)
		else $error("loaded result not presented");

	a_final_bit_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accum && stat.matrix_end) |=> (state_q == ST_SCAN))
		else $error("final bit did not start the column scan");

	a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !cmd.accum)
		else $error("bit accepted during column scan");

endmodule

// ===== src/tdp_datapath.sv =====
// ----------------------------------------------------------------------------
// tdp_datapath
// Datapath: size register, row and column parity accumulators, column scan
// shifter and the result register.
// ----------------------------------------------------------------------------
module tdp_datapath
	import tdp_pkg::*;
#(
	parameter int MAX_SIZE = MAX_SIZE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tdp_cmd_t             cmd,
	input  logic [SIZE_W-1:0]    cfg_size,
	input  logic                 data_bit,
	output tdp_stat_t            stat,
	output logic [VERDICT_W-1:0] verdict,
	output logic [INDEX_W-1:0]   error_row,
	output logic [INDEX_W-1:0]   error_column
);

	localparam int IW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int SW = $clog2(MAX_SIZE + 1);
	localparam int CW = (SW > SIZE_W) ? SW : SIZE_W;

	logic [SIZE_W-1:0]   size_q;
	logic [SW-1:0]       eff_size;
	logic [IW-1:0]       col_q;
	logic [IW-1:0]       row_q;
	logic                row_par_q;
	logic [1:0]          odd_rows_q;
	logic [SW-1:0]       odd_row_idx_q;
	logic [MAX_SIZE-1:0] col_par_q;
	logic [IW-1:0]       scan_q;
	logic [1:0]          odd_cols_q;
	logic [SW-1:0]       odd_col_idx_q;
	logic                col_end;
	logic                row_end;
	logic                row_odd;
	logic [1:0]          odd_cols_n;
	logic [SW-1:0]       odd_col_idx_n;
	logic [VERDICT_W-1:0] verdict_n;

	always_comb begin
		if (size_q == '0) begin
			eff_size = SW'(1);
		end else if (CW'(size_q) > CW'(MAX_SIZE)) begin
			eff_size = SW'(MAX_SIZE);
		end else begin
			eff_size = SW'(size_q);
		end
	end

	assign col_end         = (SW'(col_q) + SW'(1)) == eff_size;
	assign row_end         = (SW'(row_q) + SW'(1)) == eff_size;
	assign row_odd         = row_par_q ^ data_bit;
	assign stat.matrix_end = col_end && row_end;
	assign stat.scan_last  = (SW'(scan_q) + SW'(1)) == eff_size;

	always_comb begin
		odd_cols_n    = odd_cols_q;
		odd_col_idx_n = odd_col_idx_q;
		if (col_par_q[0]) begin
			if (odd_cols_q != COUNT_SAT) begin
				odd_cols_n = odd_cols_q + 2'd1;
			end
			odd_col_idx_n = SW'(scan_q) + SW'(1);
		end
	end

	always_comb begin
		if (odd_rows_q == COUNT_NONE && odd_cols_n == COUNT_NONE) begin
			verdict_n = VERDICT_OK;
		end else if (odd_rows_q == COUNT_ONE && odd_cols_n == COUNT_ONE) begin
			verdict_n = VERDICT_SINGLE;
		end else begin
			verdict_n = VERDICT_CORRUPT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (cmd.clear) begin
			size_q <= cfg_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q         <= '0;
			row_q         <= '0;
			row_par_q     <= 1'b0;
			odd_rows_q    <= COUNT_NONE;
			odd_row_idx_q <= '0;
			col_par_q     <= '0;
			scan_q        <= '0;
			odd_cols_q    <= COUNT_NONE;
			odd_col_idx_q <= '0;
		end else if (cmd.clear) begin
			col_q         <= '0;
			row_q         <= '0;
			row_par_q     <= 1'b0;
			odd_rows_q    <= COUNT_NONE;
			odd_row_idx_q <= '0;
			col_par_q     <= '0;
			scan_q        <= '0;
			odd_cols_q    <= COUNT_NONE;
			odd_col_idx_q <= '0;
		end else if (cmd.accum) begin
			col_par_q[col_q] <= col_par_q[col_q] ^ data_bit;
			if (col_end) begin
				col_q     <= '0;
				row_par_q <= 1'b0;
				if (row_odd) begin
					if (odd_rows_q != COUNT_SAT) begin
						odd_rows_q <= odd_rows_q + 2'd1;
					end
					odd_row_idx_q <= SW'(row_q) + SW'(1);
				end
				row_q <= row_end ? '0 : row_q + IW'(1);
			end else begin
				col_q     <= col_q + IW'(1);
				row_par_q <= row_odd;
			end
		end else if (cmd.scan) begin
			// shifting zeros in leaves the vector clear after the last step
			col_par_q <= col_par_q >> 1;
			if (cmd.load) begin
				scan_q        <= '0;
				odd_cols_q    <= COUNT_NONE;
				odd_col_idx_q <= '0;
				odd_rows_q    <= COUNT_NONE;
				odd_row_idx_q <= '0;
			end else begin
				scan_q        <= scan_q + IW'(1);
				odd_cols_q    <= odd_cols_n;
				odd_col_idx_q <= odd_col_idx_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			verdict <= verdict_n;
			if (verdict_n == VERDICT_SINGLE) begin
				error_row    <= INDEX_W'(odd_row_idx_q);
				error_column <= INDEX_W'(odd_col_idx_n);
			end else begin
				error_row    <= '0;
				error_column <= '0;
			end
		end
	end

endmodule

// ===== src/two_dim_parity_checker.sv =====
// ----------------------------------------------------------------------------
// two_dim_parity_checker
// Checks row and column parity of a square bit matrix streamed in row-major
// order and reports ok, a located single-bit error, or corrupt.
//
//   channel  role   payload                               transfer
//   bits     sink   data_bit                              valid && ready
//   result   source verdict, error_row, error_column      valid && ready
//   cfg      sink   matrix_size                           valid && ready
//
// One bit is taken per cycle while a matrix streams in, unless a cfg
// transfer is pending. After the final bit the column parity vector is
// shifted out one column per cycle. The result waits in an output register;
// the next matrix streams in meanwhile and its scan holds on its last step
// until that register is free. A cfg transfer clears all accumulators and is
// held off during a scan. Reset is asynchronous; size resets to 1.
// ----------------------------------------------------------------------------
module two_dim_parity_checker
	import tdp_pkg::*;
#(
	parameter int MAX_SIZE = MAX_SIZE_DEF
) (
	input logic       clk,
	input logic       arst_n,
	tdp_bit_if.sink   bits,
	tdp_result_if.source result,
	tdp_cfg_if.sink   cfg
);

	tdp_cmd_t  cmd;
	tdp_stat_t stat;

	tdp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (bits.valid),
		.in_ready  (bits.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cfg_valid (cfg.valid),
		.cfg_ready (cfg.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tdp_datapath #(
		.MAX_SIZE (MAX_SIZE)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_size     (cfg.matrix_size),
		.data_bit     (bits.data_bit),
		.stat         (stat),
		.verdict      (result.verdict),
		.error_row    (result.error_row),
		.error_column (result.error_column)
	);

endmodule
